FILE: hw/rtl/srtcp_pkg.sv
// ----------------------------------------------------------------------------
// srtcp_pkg
// Shared types and constants of the subtitle cue stream parser: operation
// words passed from the parsing front to the result back, result kinds,
// timing field weights and the timing line pattern.
// ----------------------------------------------------------------------------
`default_nettype none

package srtcp_pkg;

   localparam int unsigned MS_WIDTH    = 29;
   localparam int unsigned DIGIT_WIDTH = 10;
   localparam int unsigned COL_WIDTH   = 5;

   localparam logic [COL_WIDTH-1:0] TIMING_LEN     = 5'd29;
   localparam logic [COL_WIDTH-1:0] END_FIELD_COL  = 5'd17;
   localparam logic [COL_WIDTH-1:0] START_MS_COL   = 5'd11;
   localparam logic [COL_WIDTH-1:0] END_MS_COL     = 5'd28;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_GT    = 8'h3E;
   // marks a digit position in the timing pattern
   localparam logic [7:0] CHAR_DIGIT = 8'h44;

   localparam logic [21:0] WEIGHT_HOURS   = 22'd3600000;
   localparam logic [21:0] WEIGHT_MINUTES = 22'd60000;
   localparam logic [21:0] WEIGHT_SECONDS = 22'd1000;
   localparam logic [21:0] WEIGHT_MILLIS  = 22'd1;

   typedef enum logic [1:0] {
      KIND_TEXT  = 2'd0,
      KIND_CLOSE = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_FOLD  = 2'd1,
      OP_EMIT  = 2'd2
   } op_code_type;

   typedef enum logic [1:0] {
      WSEL_HOURS   = 2'd0,
      WSEL_MINUTES = 2'd1,
      WSEL_SECONDS = 2'd2,
      WSEL_MILLIS  = 2'd3
   } weight_sel_type;

   typedef struct packed {
      op_code_type             code;
      logic                    to_end;
      weight_sel_type          weight;
      logic [DIGIT_WIDTH-1:0]  digit;
      kind_type                kind;
      logic                    first;
      logic [7:0]              text;
   } op_type;

   // expected byte at each timing line column, "DD:DD:DD,DDD --> DD:DD:DD,DDD"
   function automatic logic [7:0] pattern_char(input logic [COL_WIDTH-1:0] col);
      logic [7:0] ch;
      case (col)
         5'd2, 5'd5, 5'd19, 5'd22: ch = CHAR_COLON;
         5'd8, 5'd25:              ch = CHAR_COMMA;
         5'd12, 5'd16:             ch = CHAR_SPACE;
         5'd13, 5'd14:             ch = CHAR_DASH;
         5'd15:                    ch = CHAR_GT;
         default:                  ch = CHAR_DIGIT;
      endcase
      return ch;
   endfunction

   function automatic logic [21:0] weight_value(input weight_sel_type sel);
      logic [21:0] w;
      case (sel)
         WSEL_HOURS:   w = WEIGHT_HOURS;
         WSEL_MINUTES: w = WEIGHT_MINUTES;
         WSEL_SECONDS: w = WEIGHT_SECONDS;
         WSEL_MILLIS:  w = WEIGHT_MILLIS;
         default:      w = WEIGHT_MILLIS;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/srtcp_req_if.sv
// ----------------------------------------------------------------------------
// srtcp_req_if
// Input channel: one file byte or an end of stream mark per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface srtcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       stream_end;

   modport source (output valid, output data_byte, output stream_end, input ready);
   modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/srtcp_rsp_if.sv
// ----------------------------------------------------------------------------
// srtcp_rsp_if
// Result channel: text bytes, cue close and format error words.
// ----------------------------------------------------------------------------
`default_nettype none

interface srtcp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic        first_of_cue;
   logic [28:0] start_ms;
   logic [28:0] end_ms;
   logic [7:0]  text_byte;

   modport source (output valid, output kind, output first_of_cue, output start_ms,
                   output end_ms, output text_byte, input ready);
   modport sink   (input valid, input kind, input first_of_cue, input start_ms,
                   input end_ms, input text_byte, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/srtcp_front.sv
// ----------------------------------------------------------------------------
// srtcp_front
// Parsing front: takes one byte a cycle unless the operation queue is full, tracks
// the cue line structure, checks the timing line column by column and issues operation words.
// ----------------------------------------------------------------------------
`default_nettype none

module srtcp_front
   import srtcp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   srtcp_req_if.sink     req,
   input  logic          queue_full,
   output logic          push_valid,
   output op_type        push_op
);

   typedef enum logic [2:0] {
      PH_INDEX      = 3'd0,
      PH_TIMING     = 3'd1,
      PH_LINE_START = 3'd2,
      PH_IN_LINE    = 3'd3,
      PH_BLANK_REST = 3'd4,
      PH_HALT       = 3'd5
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [COL_WIDTH-1:0]   column_ff, column_in;
   logic [DIGIT_WIDTH-1:0] digit_ff, digit_in;
   logic                   text_seen_ff, text_seen_in;

   logic                   accept;
   logic [7:0]             b;
   logic [7:0]             expect_ch;
   logic                   is_digit;
   logic                   col_ok;
   logic [DIGIT_WIDTH-1:0] digit_times10;
   logic [DIGIT_WIDTH-1:0] digit_next;
   logic                   fold;
   logic                   to_end;
   logic [COL_WIDTH-1:0]   rel_col;
   weight_sel_type         wsel;

   assign req.ready = !queue_full;
   assign accept    = req.valid && !queue_full;
   assign b         = req.data_byte;

   assign expect_ch     = pattern_char(column_ff);
   assign is_digit      = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   assign col_ok        = (expect_ch == CHAR_DIGIT) ? is_digit : (b == expect_ch);
   assign digit_times10 = {digit_ff[DIGIT_WIDTH-4:0], 3'b000}
                        + {digit_ff[DIGIT_WIDTH-2:0], 1'b0};
   assign digit_next    = (expect_ch == CHAR_DIGIT) ?
                          (digit_times10 + DIGIT_WIDTH'(b[3:0])) : digit_ff;
   // a field ends on its separator, or on the last millisecond digit
   assign fold          = (column_ff == START_MS_COL) || (column_ff == END_MS_COL)
                        || (expect_ch == CHAR_COLON) || (expect_ch == CHAR_COMMA);
   assign to_end        = (column_ff >= END_FIELD_COL);
   assign rel_col       = to_end ? (column_ff - END_FIELD_COL) : column_ff;

   always_comb begin
      case (rel_col)
         5'd2:    wsel = WSEL_HOURS;
         5'd5:    wsel = WSEL_MINUTES;
         5'd8:    wsel = WSEL_SECONDS;
         default: wsel = WSEL_MILLIS;
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      column_in    = column_ff;
      digit_in     = digit_ff;
      text_seen_in = text_seen_ff;
      push_valid   = 1'b0;
      push_op      = '{code: OP_EMIT, to_end: 1'b0, weight: WSEL_MILLIS,
                       digit: '0, kind: KIND_TEXT, first: 1'b0, text: '0};
      if (accept) begin
         if (req.stream_end) begin
            if (((phase_ff == PH_LINE_START) || (phase_ff == PH_IN_LINE)) && text_seen_ff) begin
               push_valid   = 1'b1;
               push_op.kind = KIND_CLOSE;
            end
            phase_in     = PH_INDEX;
            column_in    = '0;
            digit_in     = '0;
            text_seen_in = 1'b0;
         end else begin
            case (phase_ff)
               PH_INDEX: begin
                  if (b == CHAR_LF) begin
                     phase_in     = PH_TIMING;
                     column_in    = '0;
                     digit_in     = '0;
                     push_valid   = 1'b1;
                     push_op.code = OP_CLEAR;
                  end
               end
               PH_TIMING: begin
                  if (column_ff >= TIMING_LEN) begin
                     if (b == CHAR_LF) begin
                        phase_in     = PH_LINE_START;
                        text_seen_in = 1'b0;
                     end
                  end else if (!col_ok) begin
                     phase_in     = PH_HALT;
                     push_valid   = 1'b1;
                     push_op.kind = KIND_ERROR;
                  end else begin
                     column_in = column_ff + 1'b1;
                     if (fold) begin
                        digit_in       = '0;
                        push_valid     = 1'b1;
                        push_op.code   = OP_FOLD;
                        push_op.to_end = to_end;
                        push_op.weight = wsel;
                        push_op.digit  = digit_next;
                     end else begin
                        digit_in = digit_next;
                     end
                  end
               end
               PH_LINE_START: begin
                  if ((b == CHAR_LF) || (b == CHAR_CR)) begin
                     if (text_seen_ff) begin
                        push_valid   = 1'b1;
                        push_op.kind = KIND_CLOSE;
                     end
                     text_seen_in = 1'b0;
                     phase_in     = (b == CHAR_LF) ? PH_INDEX : PH_BLANK_REST;
                  end else begin
                     push_valid    = 1'b1;
                     push_op.first = !text_seen_ff;
                     push_op.text  = b;
                     text_seen_in  = 1'b1;
                     phase_in      = PH_IN_LINE;
                  end
               end
               PH_IN_LINE: begin
                  push_valid   = 1'b1;
                  push_op.text = b;
                  if (b == CHAR_LF) begin
                     phase_in = PH_LINE_START;
                  end
               end
               PH_BLANK_REST: begin
                  if (b == CHAR_LF) begin
                     phase_in = PH_INDEX;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_INDEX;
         column_ff    <= '0;
         digit_ff     <= '0;
         text_seen_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         column_ff    <= column_in;
         digit_ff     <= digit_in;
         text_seen_ff <= text_seen_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/srtcp_queue.sv
// ----------------------------------------------------------------------------
// srtcp_queue
// Short first-in first-out queue of operation words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module srtcp_queue
   import srtcp_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  op_type  push_op,
   output logic    full,
   output logic    pop_valid,
   output op_type  pop_op,
   input  logic    pop
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   op_type          entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full      = (count_ff == FULL_COUNT);
   assign pop_valid = (count_ff != '0);
   assign pop_op    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("queue occupancy beyond depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push_valid && !pop) |=> (count_ff != '0))
      else $error("queue lost a word");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/srtcp_back.sv
// ----------------------------------------------------------------------------
// srtcp_back
// Result back: holds the cue time accumulators, folds timing fields into
// them and drives the registered result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module srtcp_back
   import srtcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        pop_valid,
   input  op_type      pop_op,
   output logic        pop,
   srtcp_rsp_if.source rsp
);

   logic [MS_WIDTH-1:0] start_ff, start_in;
   logic [MS_WIDTH-1:0] end_ff, end_in;
   logic                rsp_valid_ff, rsp_valid_in;
   kind_type            kind_ff, kind_in;
   logic                first_ff, first_in;
   logic [MS_WIDTH-1:0] start_out_ff, start_out_in;
   logic [MS_WIDTH-1:0] end_out_ff, end_out_in;
   logic [7:0]          text_ff, text_in;

   logic                out_free;
   logic [31:0]         product;
   logic [MS_WIDTH-1:0] base;
   logic [MS_WIDTH-1:0] sum;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign pop      = pop_valid && ((pop_op.code != OP_EMIT) || out_free);

   // digit field times a constant weight, then one add into the accumulator
   assign product = 32'(pop_op.digit) * 32'(weight_value(pop_op.weight));
   assign base    = pop_op.to_end ? end_ff : start_ff;
   assign sum     = base + product[MS_WIDTH-1:0];

   always_comb begin
      start_in     = start_ff;
      end_in       = end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      kind_in      = kind_ff;
      first_in     = first_ff;
      start_out_in = start_out_ff;
      end_out_in   = end_out_ff;
      text_in      = text_ff;
      if (pop) begin
         case (pop_op.code)
            OP_CLEAR: begin
               start_in = '0;
               end_in   = '0;
            end
            OP_FOLD: begin
               if (pop_op.to_end) begin
                  end_in = sum;
               end else begin
                  start_in = sum;
               end
            end
            OP_EMIT: begin
               rsp_valid_in = 1'b1;
               kind_in      = pop_op.kind;
               first_in     = pop_op.first;
               text_in      = pop_op.text;
               start_out_in = (pop_op.kind == KIND_ERROR) ? '0 : start_ff;
               end_out_in   = (pop_op.kind == KIND_ERROR) ? '0 : end_ff;
            end
            default: begin
               start_in = start_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         start_ff     <= '0;
         end_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         start_ff     <= start_in;
         end_ff       <= end_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      first_ff     <= first_in;
      start_out_ff <= start_out_in;
      end_out_ff   <= end_out_in;
      text_ff      <= text_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.kind         = kind_ff;
   assign rsp.first_of_cue = first_ff;
   assign rsp.start_ms     = start_out_ff;
   assign rsp.end_ms       = end_out_ff;
   assign rsp.text_byte    = text_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/srt_cue_stream_parser_core.sv
// Path: a result word goes via the operation queue and the result register to rsp.
// Throughput: one byte per cycle; every byte causes at most one queue word and the
// back retires one word per cycle while the result register drains.
// Input stalls only when the operation queue (QUEUE_DEPTH words) is full.
// Reset: synchronous; parser returns to index skipping, queue and result register empty.
// ----------------------------------------------------------------------------
// srt_cue_stream_parser_core
// Subtitle cue stream parser: parsing front, operation queue and result back.
// ----------------------------------------------------------------------------
`default_nettype none

module srt_cue_stream_parser_core
   import srtcp_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)(
   input  logic        clock,
   input  logic        reset,
   srtcp_req_if.sink   req,
   srtcp_rsp_if.source rsp
);

   logic   queue_full;
   logic   push_valid;
   op_type push_op;
   logic   pop_valid;
   op_type pop_op;
   logic   pop;

   srtcp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_op    (push_op)
   );

   srtcp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_op    (push_op),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_op     (pop_op),
      .pop        (pop)
   );

   srtcp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_op    (pop_op),
      .pop       (pop),
      .rsp       (rsp)
   );

endmodule

`default_nettype wire

FILE: tb/sv/tb_srt_cue_stream_parser_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_srt_cue_stream_parser_core
// Streams subtitle bytes into the cue parser. A short table of directed words
// comes first. Most of the rest is well-formed cues with random times and
// text, mixed with broken timing lines, noise bytes and early end of stream.
// Every result word is checked field by field against a predictor that is
// stepped on each accepted input word.
// ----------------------------------------------------------------------------
module tb_srt_cue_stream_parser_core;
   import srtcp_pkg::*;

   localparam int unsigned WORK_TARGET   = 1900;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned IDLE_PCT      = 29;
   localparam int unsigned DIRECTED_ROWS = 20;
   localparam logic [8*29-1:0] TIMING_SHAPE = "DD:DD:DD,DDD --> DD:DD:DD,DDD";

   typedef enum logic [2:0] {
      SKIP_INDEX, TIMING_LINE, LINE_START, IN_LINE, BLANK_TAIL, HALTED
   } parse_phase_type;

   typedef struct packed {
      kind_type              kind;
      logic                  first;
      logic [MS_WIDTH-1:0]   start_ms;
      logic [MS_WIDTH-1:0]   end_ms;
      logic [7:0]            text;
   } cue_word_type;

   typedef struct packed {
      logic         at_end;
      logic [7:0]   data;
      logic         typed;
      cue_word_type want;
   } stim_row_type;

   localparam cue_word_type NO_WORD   = '0;
   localparam cue_word_type HALT_WORD = '{KIND_ERROR, 1'b0, 29'd0, 29'd0, 8'h00};

   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // end of stream on a fresh parser, then index bytes at the byte extremes
      '{1'b1, 8'hFF, 1'b0, NO_WORD},
      '{1'b0, 8'h00, 1'b0, NO_WORD},
      '{1'b0, 8'hFF, 1'b0, NO_WORD},
      '{1'b0, CHAR_CR, 1'b0, NO_WORD},
      '{1'b0, CHAR_LF, 1'b0, NO_WORD},
      // non-digit where an hour digit belongs
      '{1'b0, CHAR_NINE, 1'b0, NO_WORD},
      '{1'b0, 8'h00, 1'b1, HALT_WORD},
      // halted: bytes and end of stream give nothing
      '{1'b0, 8'hFF, 1'b0, NO_WORD},
      '{1'b0, CHAR_LF, 1'b0, NO_WORD},
      '{1'b1, 8'h00, 1'b0, NO_WORD},
      // short timing line
      '{1'b0, CHAR_LF, 1'b0, NO_WORD},
      '{1'b0, CHAR_ZERO, 1'b0, NO_WORD},
      '{1'b0, CHAR_ZERO, 1'b0, NO_WORD},
      '{1'b0, CHAR_LF, 1'b1, HALT_WORD},
      '{1'b1, 8'hFF, 1'b0, NO_WORD},
      // wrong separator after the hours
      '{1'b0, CHAR_LF, 1'b0, NO_WORD},
      '{1'b0, "2", 1'b0, NO_WORD},
      '{1'b0, "3", 1'b0, NO_WORD},
      '{1'b0, ";", 1'b1, HALT_WORD},
      '{1'b1, 8'h00, 1'b0, NO_WORD}
   };

   logic clock = 1'b0;
   logic reset;

   srtcp_req_if req_bus ();
   srtcp_rsp_if rsp_bus ();

   srt_cue_stream_parser_core u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   parse_phase_type     p_phase;
   logic [4:0]          p_col;
   logic [MS_WIDTH-1:0] p_start;
   logic [MS_WIDTH-1:0] p_end;
   logic [9:0]          p_digits;
   logic                p_has_text;

   cue_word_type expected_words [$];
   bit          steady = 1'b0;
   int unsigned words_sent  = 0;
   int unsigned work_items  = 0;
   int unsigned text_words  = 0;
   int unsigned close_words = 0;
   int unsigned halt_words  = 0;
   int unsigned fail_count  = 0;
   int unsigned cycle_count = 0;

   function automatic logic [7:0] shape_at(input logic [4:0] col);
      return TIMING_SHAPE[8*(28-col) +: 8];
   endfunction

   function automatic void clear_parser();
      p_phase    = SKIP_INDEX;
      p_col      = '0;
      p_start    = '0;
      p_end      = '0;
      p_digits   = '0;
      p_has_text = 1'b0;
   endfunction

   task automatic predict_word(input logic at_end, input logic [7:0] b,
                               output bit got, output cue_word_type w);
      logic [7:0]  shape;
      logic [4:0]  rel;
      logic [21:0] weight;
      logic [31:0] scaled;
      bit          ok;
      got = 1'b0;
      w   = '{KIND_TEXT, 1'b0, p_start, p_end, b};
      if (at_end) begin
         if ((p_phase == LINE_START || p_phase == IN_LINE) && p_has_text) begin
            got    = 1'b1;
            w.kind = KIND_CLOSE;
            w.text = '0;
         end
         clear_parser();
      end else begin
         case (p_phase)
            SKIP_INDEX: begin
               if (b == CHAR_LF) begin
                  p_phase  = TIMING_LINE;
                  p_col    = '0;
                  p_start  = '0;
                  p_end    = '0;
                  p_digits = '0;
               end
            end
            TIMING_LINE: begin
               if (p_col >= TIMING_LEN) begin
                  // tail of the timing line is ignored up to its line feed
                  if (b == CHAR_LF) begin
                     p_phase    = LINE_START;
                     p_has_text = 1'b0;
                  end
               end else begin
                  shape = shape_at(p_col);
                  if (shape == CHAR_DIGIT) begin
                     ok = (b >= CHAR_ZERO && b <= CHAR_NINE);
                     if (ok) p_digits = 10'(p_digits * 10 + (b - CHAR_ZERO));
                  end else begin
                     ok = (b == shape);
                  end
                  if (!ok) begin
                     p_phase = HALTED;
                     got     = 1'b1;
                     w       = HALT_WORD;
                  end else begin
                     rel = (p_col >= END_FIELD_COL) ? p_col - END_FIELD_COL : p_col;
                     case (rel)
                        5'd2:    weight = WEIGHT_HOURS;
                        5'd5:    weight = WEIGHT_MINUTES;
                        5'd8:    weight = WEIGHT_SECONDS;
                        5'd11:   weight = WEIGHT_MILLIS;
                        default: weight = '0;
                     endcase
                     if (weight != '0) begin
                        scaled = 32'(p_digits) * 32'(weight);
                        if (p_col >= END_FIELD_COL) p_end = p_end + scaled[MS_WIDTH-1:0];
                        else p_start = p_start + scaled[MS_WIDTH-1:0];
                        p_digits = '0;
                     end
                     p_col = p_col + 5'd1;
                  end
               end
            end
            LINE_START: begin
               if (b == CHAR_LF || b == CHAR_CR) begin
                  if (p_has_text) begin
                     got    = 1'b1;
                     w.kind = KIND_CLOSE;
                     w.text = '0;
                  end
                  p_has_text = 1'b0;
                  p_phase    = (b == CHAR_LF) ? SKIP_INDEX : BLANK_TAIL;
               end else begin
                  got        = 1'b1;
                  w.first    = !p_has_text;
                  p_has_text = 1'b1;
                  p_phase    = IN_LINE;
               end
            end
            IN_LINE: begin
               got = 1'b1;
               if (b == CHAR_LF) p_phase = LINE_START;
            end
            BLANK_TAIL: begin
               if (b == CHAR_LF) p_phase = SKIP_INDEX;
            end
            default: ;
         endcase
      end
   endtask

   task automatic send_word(input logic at_end, input logic [7:0] b,
                            input bit typed, input cue_word_type want);
      bit           got;
      bit           counted;
      cue_word_type w;
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.data_byte  <= b;
      req_bus.stream_end <= at_end;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      counted = (p_phase != HALTED);
      predict_word(at_end, b, got, w);
      if (typed) expected_words.push_back(want);
      else if (got) expected_words.push_back(w);
      words_sent++;
      if (counted) work_items++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_word(1'b0, b, 1'b0, NO_WORD);
   endtask

   task automatic send_end();
      send_word(1'b1, 8'($urandom_range(0, 255)), 1'b0, NO_WORD);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
   endtask

   function automatic logic [7:0] random_not_lf();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == CHAR_LF);
      return c;
   endfunction

   task automatic send_index();
      repeat ($urandom_range(0, 4)) begin
         if ($urandom_range(0, 3) == 0) send_byte(random_not_lf());
         else send_byte(8'(CHAR_ZERO + $urandom_range(0, 9)));
      end
      if ($urandom_range(0, 3) == 0) send_byte(CHAR_CR);
      send_byte(CHAR_LF);
   endtask

   // shape_mode: 0 random digits, 1 all zeros, 2 all nines
   task automatic send_timing(input int unsigned shape_mode, output bit intact);
      int unsigned cut;
      int unsigned how;
      logic [7:0]  shape;
      logic [7:0]  c;
      cut = 29;
      how = 0;
      if (shape_mode == 0 && $urandom_range(0, 99) < 12) begin
         cut = $urandom_range(0, 28);
         how = $urandom_range(0, 9);
      end
      for (int col = 0; col < cut; col++) begin
         shape = shape_at(5'(col));
         if (shape != CHAR_DIGIT) c = shape;
         else if (shape_mode == 1) c = CHAR_ZERO;
         else if (shape_mode == 2) c = CHAR_NINE;
         else c = 8'(CHAR_ZERO + $urandom_range(0, 9));
         send_byte(c);
      end
      intact = (cut == 29);
      if (!intact) begin
         if (how == 9) begin
            // stream ends inside the timing line
            send_end();
         end else begin
            if (how >= 6) begin
               send_byte(CHAR_LF);
            end else begin
               shape = shape_at(5'(cut));
               do c = 8'($urandom_range(0, 255));
               while (shape == CHAR_DIGIT ? (c >= CHAR_ZERO && c <= CHAR_NINE) : c == shape);
               send_byte(c);
            end
            repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 255)));
            send_end();
         end
      end else begin
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_byte(random_not_lf());
         if ($urandom_range(0, 2) == 0) send_byte(CHAR_CR);
         send_byte(CHAR_LF);
      end
   endtask

   task automatic send_text_line();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == CHAR_LF || c == CHAR_CR);
      send_byte(c);
      repeat ($urandom_range(0, 7)) send_byte(random_not_lf());
      send_byte(CHAR_LF);
   endtask

   task automatic send_cue(input int unsigned round);
      int unsigned pick;
      int unsigned shape_mode;
      bit          intact;
      pick = (round < 2) ? 99 : $urandom_range(0, 99);
      if (pick < 6) begin
         repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 9) < 7) send_end();
      end else if (pick < 9) begin
         send_end();
      end else begin
         if (round < 2) shape_mode = round + 1;
         else if ($urandom_range(0, 19) == 0) shape_mode = $urandom_range(1, 2);
         else shape_mode = 0;
         send_index();
         send_timing(shape_mode, intact);
         if (intact) begin
            // a cue with no text now and then
            if ($urandom_range(0, 9) != 0) repeat ($urandom_range(1, 3)) send_text_line();
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               send_byte(CHAR_LF);
            end else if (pick < 85) begin
               send_byte(CHAR_CR);
               repeat ($urandom_range(0, 2)) send_byte(random_not_lf());
               send_byte(CHAR_LF);
            end else begin
               send_end();
            end
         end
      end
   endtask

   task automatic note_failure(input string what, input cue_word_type want,
                               input cue_word_type seen);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%s: expected kind %0d first %0d start %0d end %0d byte %02h",
                  what, want.kind, want.first, want.start_ms, want.end_ms, want.text);
         $display("   got kind %0d first %0d start %0d end %0d byte %02h",
                  seen.kind, seen.first, seen.start_ms, seen.end_ms, seen.text);
      end
   endtask

   always @(posedge clock) begin : check_results
      cue_word_type want;
      cue_word_type seen;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         seen = '{kind_type'(rsp_bus.kind), rsp_bus.first_of_cue, rsp_bus.start_ms,
                  rsp_bus.end_ms, rsp_bus.text_byte};
         case (seen.kind)
            KIND_TEXT:  text_words++;
            KIND_CLOSE: close_words++;
            default:    halt_words++;
         endcase
         if (expected_words.size() == 0) begin
            note_failure("unexpected result word", NO_WORD, seen);
         end else begin
            want = expected_words.pop_front();
            if (seen.kind !== want.kind || seen.first !== want.first ||
                seen.start_ms !== want.start_ms || seen.end_ms !== want.end_ms ||
                seen.text !== want.text)
               note_failure("result word mismatch", want, seen);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d result words outstanding",
                  cycle_count, expected_words.size());
         $display("srt_cue_stream_parser_core test failed");
         $finish;
      end
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   initial begin : stimulus
      int unsigned round;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.data_byte  = 8'h00;
      req_bus.stream_end = 1'b0;
      clear_parser();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_word(DIRECTED[i].at_end, DIRECTED[i].data, DIRECTED[i].typed, DIRECTED[i].want);

      round = 0;
      while (work_items < WORK_TARGET) begin
         // a long stretch where neither side idles
         steady = (work_items >= 700 && work_items < 1000);
         if (round % 10 == 9) wait_for_drain();
         send_cue(round);
         round++;
      end
      steady = 1'b0;

      wait_for_drain();
      repeat (10) @(posedge clock);
      $display("sent %0d input words (%0d outside a halt) over %0d cue rounds",
               words_sent, work_items, round);
      $display("checked %0d text, %0d cue close, %0d format error words; %0d mismatches",
               text_words, close_words, halt_words, fail_count);
      if (fail_count == 0) begin
         $display("srt_cue_stream_parser_core test passed");
      end else begin
         $display("srt_cue_stream_parser_core test failed");
      end
      $finish;
   end

endmodule
